// ===== hw/rtl/prt_pkg.sv =====
`default_nettype none

package prt_pkg;

	localparam int ENTRIES_DEF = 10;
	localparam int ID_W = 16;
	localparam int TIME_W = 48;
	localparam int AVG_W = 32;
	localparam int QUO_W = AVG_W - 1;

	localparam logic [1:0] OP_SEND  = 2'd0;
	localparam logic [1:0] OP_RECV  = 2'd1;
	localparam logic [1:0] OP_AVG   = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [ID_W-1:0]   ping_id;
		logic [TIME_W-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]         new_id;
		logic signed [AVG_W-1:0] average_ms;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] sent;
		logic [TIME_W-1:0] recv;
	} entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/prt_mem.sv =====
`default_nettype none

module prt_mem #(
	parameter int ENTRIES = prt_pkg::ENTRIES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          clr,
	input  wire                          rd_en,
	input  wire [$clog2(ENTRIES)-1:0]    rd_addr,
	output prt_pkg::entry_t              rd_data,
	input  wire                          wr_en,
	input  wire [$clog2(ENTRIES)-1:0]    wr_addr,
	input  prt_pkg::entry_t              wr_data
);
	import prt_pkg::*;

	entry_t               mem_q [ENTRIES];
	logic [ENTRIES-1:0]   vld_q;
	entry_t               rd_q;
	logic                 rd_vld_q;

	// read returns old data on a same-address write; the sequencer never overlaps them
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr)
				vld_q <= '0;
			else if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
		end
	end

	// never-written entries read as zero
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/prt_div.sv =====
`default_nettype none

module prt_div #(
	parameter int CW = 4
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire [prt_pkg::QUO_W-1:0]    dvd,
	input  wire [CW-1:0]                dvs,
	output logic                        done,
	output logic [prt_pkg::QUO_W-1:0]   quo
);
	import prt_pkg::*;

	localparam int NW = $clog2(QUO_W);

	logic              run_q;
	logic              done_q;
	logic [NW-1:0]     cnt_q;
	logic [QUO_W-1:0]  dvd_q;
	logic [CW-1:0]     dvs_q;
	logic [CW-1:0]     rem_q;
	logic [CW:0]       rem_sh;
	logic [CW:0]       dif;
	logic              qbit;

	// restoring divide, one quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q, dvd_q[QUO_W-1]};
		dif    = rem_sh - {1'b0, dvs_q};
		qbit   = ~dif[CW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= NW'(QUO_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0)
					run_q <= 1'b0;
				else
					cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dvd;
			dvs_q <= dvs;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[QUO_W-2:0], qbit};
			rem_q <= qbit ? dif[CW-1:0] : rem_sh[CW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = dvd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ping_round_trip_tracker.sv =====
`default_nettype none

// Ping round-trip tracker.
// Command channel: req (opcode, ping_id, now_ms) is taken on a rising edge with
// start high and busy low. Every command returns exactly one result beat on rsp,
// marked by a one-cycle done strobe; the receiver takes it unconditionally.
// Opcodes: send (new_id = previous head id + 1, wraps at 16 bits), receive (stamp
// first record in index order whose id matches), average (half mean round trip,
// truncated), clear. Unused result fields read zero.
// Work from accept to done, all records held in one synchronous memory:
//   clear     answered from idle, busy stays low
//   send      read head record, write next record
//   receive   one record read per cycle until a match
//   average   one record per cycle; result zero when nothing was measured, else
//             halve the sum magnitude, run a 31-bit bit-serial divide by the count,
//             then apply the sign
// A new command may be accepted in the cycle its predecessor's done is shown.
// Reset clears the head pointer and the per-record valid bits, so every record
// reads as zero until written; no clearing pass is needed.

module ping_round_trip_tracker #(
	parameter int ENTRIES = prt_pkg::ENTRIES_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	output logic           busy,
	input  prt_pkg::req_t  req,
	output logic           done,
	output prt_pkg::rsp_t  rsp
);
	import prt_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEND = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_PREP = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;

	logic [2:0]          state_q;
	logic [1:0]          op_q;
	logic [ID_W-1:0]     pid_q;
	logic [TIME_W-1:0]   now_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       idx_s1;
	logic [AVG_W-1:0]    sum_q;
	logic [CW-1:0]       cnt_q;
	logic                neg_q;
	logic                done_q;
	rsp_t                rsp_q;

	logic                accept;
	logic                rd_en, wr_en, clr;
	logic [AW-1:0]       rd_addr, wr_addr;
	entry_t              rd_data, wr_data;
	logic                div_start, div_done;
	logic [QUO_W-1:0]    div_quo;
	logic [AVG_W-1:0]    mag;

	logic [AW-1:0]       head_nx;
	logic                last;
	logic                match;
	logic                qual;
	logic [AVG_W-1:0]    rtt;
	logic [AVG_W-1:0]    sum_nx;
	logic [CW-1:0]       cnt_nx;
	logic                emit;
	rsp_t                rsp_nx;
	logic [2:0]          state_nx;

	prt_mem #(.ENTRIES(ENTRIES)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (clr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	prt_div #(.CW(CW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (mag[AVG_W-1:1]),
		.dvs    (cnt_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign accept  = start && (state_q == ST_IDLE);
	assign head_nx = (head_q == AW'(ENTRIES - 1)) ? '0 : head_q + AW'(1);
	assign last    = (idx_s1 == AW'(ENTRIES - 1));
	assign match   = (rd_data.id == pid_q);
	assign qual    = (rd_data.sent != '0) && (rd_data.recv != '0);
	assign rtt     = rd_data.recv[AVG_W-1:0] - rd_data.sent[AVG_W-1:0];
	assign sum_nx  = sum_q + (qual ? rtt : '0);
	assign cnt_nx  = cnt_q + CW'(qual);
	// |trunc(s/2)| = |s| >> 1
	assign mag     = sum_q[AVG_W-1] ? (~sum_q + AVG_W'(1)) : sum_q;

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = idx_s1 + AW'(1);
		wr_en     = 1'b0;
		wr_addr   = idx_s1;
		wr_data   = rd_data;
		clr       = 1'b0;
		div_start = 1'b0;
		emit      = 1'b0;
		rsp_nx    = '0;
		state_nx  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.opcode)
						OP_SEND: begin
							rd_en    = 1'b1;
							rd_addr  = head_q;
							state_nx = ST_SEND;
						end
						OP_RECV, OP_AVG: begin
							rd_en    = 1'b1;
							rd_addr  = '0;
							state_nx = ST_SCAN;
						end
						default: begin
							clr  = 1'b1;
							emit = 1'b1;
						end
					endcase
				end
			end
			ST_SEND: begin
				wr_en          = 1'b1;
				wr_addr        = head_nx;
				wr_data.id     = rd_data.id + ID_W'(1);
				wr_data.sent   = now_q;
				wr_data.recv   = '0;
				emit           = 1'b1;
				rsp_nx.new_id  = rd_data.id + ID_W'(1);
				state_nx       = ST_IDLE;
			end
			ST_SCAN: begin
				rd_en = !last;
				if (op_q == OP_RECV) begin
					if (match) begin
						wr_en        = 1'b1;
						wr_data.recv = now_q;
						emit         = 1'b1;
						state_nx     = ST_IDLE;
					end else if (last) begin
						emit     = 1'b1;
						state_nx = ST_IDLE;
					end
				end else if (last) begin
					state_nx = ST_PREP;
				end
			end
			ST_PREP: begin
				if (cnt_q == '0) begin
					emit     = 1'b1;
					state_nx = ST_IDLE;
				end else begin
					div_start = 1'b1;
					state_nx  = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					emit              = 1'b1;
					rsp_nx.average_ms = neg_q ? (~{1'b0, div_quo} + AVG_W'(1))
					                          : {1'b0, div_quo};
					state_nx          = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			idx_s1  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= emit;
			if (accept && (req.opcode == OP_CLEAR))
				head_q <= '0;
			else if (state_q == ST_SEND)
				head_q <= head_nx;
			if (accept)
				idx_s1 <= '0;
			else if (state_q == ST_SCAN)
				idx_s1 <= idx_s1 + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.opcode;
			pid_q <= req.ping_id;
			now_q <= req.now_ms;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (state_q == ST_SCAN) begin
			sum_q <= sum_nx;
			cnt_q <= cnt_nx;
		end
		if (state_q == ST_PREP)
			neg_q <= sum_q[AVG_W-1];
		if (emit)
			rsp_q <= rsp_nx;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/prt_checker.sv =====
`default_nettype none

module prt_checker (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  wire            busy,
	input  prt_pkg::req_t  req,
	input  wire            done,
	input  prt_pkg::rsp_t  rsp
);
	import prt_pkg::*;

	logic       acc;
	logic [1:0] last_op_q;

	assign acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_op_q <= OP_CLEAR;
		else if (acc)
			last_op_q <= req.opcode;
	end

	// every accepted command either starts work or answers next cycle
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (busy || done))
		else $error("accepted beat neither busy nor answered");

	a_clear_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.opcode == OP_CLEAR) |=> (done && rsp == '0))
		else $error("clear did not answer zero next cycle");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result beat");

	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last_op_q != OP_SEND) |-> (rsp.new_id == '0))
		else $error("new_id nonzero for non-send");

	a_avg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last_op_q != OP_AVG) |-> (rsp.average_ms == '0))
		else $error("average nonzero for non-average");

endmodule

bind ping_round_trip_tracker prt_checker u_prt_checker (.*);

`default_nettype wire
